[design/trilinear_charge_deposit_defines.svh]
// Assertion macros for the top-level file, which carries the checks.
`ifndef TRILINEAR_CHARGE_DEPOSIT_DEFINES_SVH
`define TRILINEAR_CHARGE_DEPOSIT_DEFINES_SVH
`ifndef SYNTHESIS
// Checks that a property holds at every rising clock edge outside reset.
`define TCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that a condition never holds outside reset.
`define TCD_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TCD_ASSERT(label, prop, msg)
`define TCD_NEVER(label, cond, msg)
`endif
`endif

[design/tcd_pkg.sv]
package tcd_pkg;

    // Item kinds.
    localparam logic KIND_DEPOSIT = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_DROPPED = 2'd1;
    localparam logic [1:0] STATUS_SAT     = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] pos_z;
        logic [11:0] node_index;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] density;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_MUL1,
        ST_MUL2,
        ST_ACC,
        ST_READ_WAIT,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic clear_wr;
        logic mul1;
        logic mul2;
        logic acc;
        logic node_rd;
        logic res_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic kind;
        logic drop;
        logic clear_done;
        logic last_corner;
        logic out_free;
    } stat_t;

endpackage

[design/tcd_ram.sv]
module tcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/tcd_datapath.sv]
module tcd_datapath #(
    parameter int CELLS_PER_AXIS = 16,
    parameter int FRAC_BITS      = 12,
    parameter int DENSITY_BITS   = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  tcd_pkg::cmd_t   cmd,
    output tcd_pkg::stat_t  stat,
    input  tcd_pkg::item_t  item,
    output logic            result_valid,
    input  logic            result_stall,
    output tcd_pkg::result_t result
);

    localparam int NODE_COUNT = CELLS_PER_AXIS * CELLS_PER_AXIS * CELLS_PER_AXIS;
    localparam int AW = $clog2(NODE_COUNT);
    localparam int FW = FRAC_BITS + 1;
    localparam int PW = 3 * FW;
    localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] HALF = PW'(1) << (2 * FRAC_BITS - 1);
    localparam logic [DENSITY_BITS-1:0] DENS_MAX = '1;

    tcd_pkg::item_t          item_reg;
    logic [2:0]              corner_reg;
    logic [AW-1:0]           clear_cnt_reg;
    logic                    sat_reg;
    logic [2*FW-1:0]         p1_reg;
    logic [PW-1:0]           prod_reg;
    logic [AW-1:0]           addr_reg;
    logic                    result_valid_reg;
    tcd_pkg::result_t        result_reg;

    logic [15:0]             ix, iy, iz;
    logic [FW-1:0]           fx, fy, fz;
    logic [31:0]             ax, ay, az, corner_addr32;
    logic [AW-1:0]           corner_addr;
    logic [AW-1:0]           node_addr;
    logic                    node_ok;
    logic [PW-1:0]           rounded;
    logic [FW-1:0]           weight;
    logic [DENSITY_BITS:0]   sum;
    logic [DENSITY_BITS-1:0] acc_value;
    logic                    acc_sat;
    logic [DENSITY_BITS-1:0] rdata;
    logic [63:0]             rd_ext;
    logic [31:0]             rd_clamped;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [DENSITY_BITS-1:0] ram_wdata;
    logic                    ram_re;
    logic [AW-1:0]           ram_raddr;

    // Split each coordinate into a node index and a factor for this corner.
    always_comb
    begin
        ix = item_reg.pos_x >> FRAC_BITS;
        iy = item_reg.pos_y >> FRAC_BITS;
        iz = item_reg.pos_z >> FRAC_BITS;
        fx = FW'(item_reg.pos_x[FRAC_BITS-1:0]);
        fy = FW'(item_reg.pos_y[FRAC_BITS-1:0]);
        fz = FW'(item_reg.pos_z[FRAC_BITS-1:0]);
        if (!corner_reg[2])
        begin
            fx = ONE - fx;
        end
        if (!corner_reg[1])
        begin
            fy = ONE - fy;
        end
        if (!corner_reg[0])
        begin
            fz = ONE - fz;
        end
        ax = 32'(ix) + 32'(corner_reg[2]);
        ay = 32'(iy) + 32'(corner_reg[1]);
        az = 32'(iz) + 32'(corner_reg[0]);
        corner_addr32 = ax * CELLS_PER_AXIS * CELLS_PER_AXIS + ay * CELLS_PER_AXIS + az;
        corner_addr = corner_addr32[AW-1:0];
    end

    // Read requests address one node directly.
    assign node_ok   = 32'(item_reg.node_index) < NODE_COUNT;
    assign node_addr = AW'(32'(item_reg.node_index));

    // Round the triple product to the grid fraction, half up.
    assign rounded = prod_reg + HALF;
    assign weight  = FW'(rounded >> (2 * FRAC_BITS));

    // Saturating accumulate against the node value just read.
    always_comb
    begin
        sum = {1'b0, rdata} + (DENSITY_BITS + 1)'(weight);
        acc_sat = sum[DENSITY_BITS];
        acc_value = acc_sat ? DENS_MAX : sum[DENSITY_BITS-1:0];
    end

    // A wide accumulator reads back clamped to the 32-bit field.
    assign rd_ext     = 64'(rdata);
    assign rd_clamped = (rd_ext > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rd_ext[31:0];

    // Memory port selection.
    always_comb
    begin
        ram_we    = cmd.clear_wr | cmd.acc;
        ram_waddr = cmd.clear_wr ? clear_cnt_reg : addr_reg;
        ram_wdata = cmd.clear_wr ? '0 : acc_value;
        ram_re    = cmd.mul2 | cmd.node_rd;
        ram_raddr = cmd.node_rd ? node_addr : corner_addr;
    end

    tcd_ram #(
        .WIDTH (DENSITY_BITS),
        .DEPTH (NODE_COUNT)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    // Control counters and flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg    <= '0;
            corner_reg       <= '0;
            sat_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clear_cnt_reg <= clear_cnt_reg + AW'(1);
            end
            if (cmd.capture)
            begin
                corner_reg <= '0;
                sat_reg    <= 1'b0;
            end
            else if (cmd.acc)
            begin
                corner_reg <= corner_reg + 3'd1;
                sat_reg    <= sat_reg | acc_sat;
            end
            if (cmd.res_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.mul1)
        begin
            p1_reg <= fx * fy;
        end
        if (cmd.mul2)
        begin
            prod_reg <= PW'(p1_reg) * PW'(fz);
            addr_reg <= corner_addr;
        end
        if (cmd.res_load)
        begin
            if (item_reg.kind == tcd_pkg::KIND_READ)
            begin
                result_reg.status  <= tcd_pkg::STATUS_OK;
                result_reg.density <= node_ok ? rd_clamped : 32'd0;
            end
            else
            begin
                result_reg.status  <= stat.drop ? tcd_pkg::STATUS_DROPPED :
                                      (sat_reg ? tcd_pkg::STATUS_SAT : tcd_pkg::STATUS_OK);
                result_reg.density <= 32'd0;
            end
        end
    end

    // Status to the controller.
    always_comb
    begin
        stat.kind        = item_reg.kind;
        stat.drop        = (32'(ix) >= CELLS_PER_AXIS - 1) || (32'(iy) >= CELLS_PER_AXIS - 1)
                        || (32'(iz) >= CELLS_PER_AXIS - 1);
        stat.clear_done  = clear_cnt_reg == AW'(NODE_COUNT - 1);
        stat.last_corner = corner_reg == 3'd7;
        stat.out_free    = !result_valid_reg || !result_stall;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[design/tcd_ctrl.sv]
module tcd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  tcd_pkg::stat_t stat,
    output tcd_pkg::cmd_t  cmd
);

    tcd_pkg::state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcd_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            tcd_pkg::ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = tcd_pkg::ST_IDLE;
                end
            end
            tcd_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = tcd_pkg::ST_DECODE;
                end
            end
            tcd_pkg::ST_DECODE:
            begin
                if (stat.kind == tcd_pkg::KIND_READ)
                begin
                    cmd.node_rd = 1'b1;
                    state_next  = tcd_pkg::ST_READ_WAIT;
                end
                else if (stat.drop)
                begin
                    state_next = tcd_pkg::ST_DONE;
                end
                else
                begin
                    state_next = tcd_pkg::ST_MUL1;
                end
            end
            tcd_pkg::ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = tcd_pkg::ST_MUL2;
            end
            tcd_pkg::ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = tcd_pkg::ST_ACC;
            end
            tcd_pkg::ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = stat.last_corner ? tcd_pkg::ST_DONE : tcd_pkg::ST_MUL1;
            end
            tcd_pkg::ST_READ_WAIT:
            begin
                state_next = tcd_pkg::ST_DONE;
            end
            tcd_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = tcd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[design/trilinear_charge_deposit.sv]
// Channel   Signals                          Payload
// item      item_valid, item_stall, item     kind, pos_x, pos_y, pos_z, node_index
// result    result_valid, result_stall, result   status, density
//
// A deposit's eight corners share one multiplier pair and one grid memory, each corner a
// read-modify-write in ST_MUL1, ST_MUL2 and ST_ACC. A read passes ST_DECODE, ST_READ_WAIT
// and ST_DONE, a dropped deposit ST_DECODE and ST_DONE; ST_DONE waits while the result
// register is held. After reset the grid is zeroed one node per cycle, before the first
// item transfer. A stalled result holds the block once its next result is ready.
`include "trilinear_charge_deposit_defines.svh"

module trilinear_charge_deposit #(
    parameter int CELLS_PER_AXIS = 16,
    parameter int FRAC_BITS      = 12,
    parameter int DENSITY_BITS   = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  tcd_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output tcd_pkg::result_t result
);

    tcd_pkg::cmd_t  cmd;
    tcd_pkg::stat_t stat;

    tcd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    tcd_datapath #(
        .CELLS_PER_AXIS (CELLS_PER_AXIS),
        .FRAC_BITS      (FRAC_BITS),
        .DENSITY_BITS   (DENSITY_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // The block takes no new item in the cycle after a transfer.
    `TCD_ASSERT(a_busy_after_transfer, (item_valid && !item_stall) |=> item_stall, "item taken while busy")
    // Status never carries an undefined code.
    `TCD_NEVER(a_status_code, result_valid && result.status > tcd_pkg::STATUS_SAT, "undefined status")
    // Dropped and saturated deposit results carry no density.
    `TCD_ASSERT(a_deposit_density, (result_valid && result.status != tcd_pkg::STATUS_OK) |-> (result.density == 32'd0), "density on a deposit result")

endmodule
